/* hw/rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of every port field; the modulus register is WIDTH bits wide.
  localparam int unsigned FIELD_W   = 32;
  // Default operand width of the datapath.
  localparam int unsigned WIDTH_DEF = 32;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_NEXT,
    S_MUL,
    S_SQR,
    S_OUT
  } mexp_state_e;

  // Operand selection for the shared multiply-reduce unit.
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MUL,
    OP_SQR
  } mexp_op_e;

endpackage

/* hw/rtl/mexp_mulred.sv */
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved shift-add multiply with reduction, one multiplier bit per cycle,
// most significant bit first. A zero modulus wraps at 2^WIDTH.
// ----------------------------------------------------------------------------
module mexp_mulred #(
  parameter int unsigned WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] mplier_i,
  input  logic [WIDTH-1:0] mcand_i,
  input  logic [WIDTH-1:0] modulus_i,
  output logic             done_o,
  output logic [WIDTH-1:0] result_o
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] mpl_q, mpl_d;
  logic [WIDTH-1:0] mcand_q, mcand_d;
  logic [WIDTH-1:0] r_q, r_d;

  logic [WIDTH+1:0] t_sum, n1, n2, c1, c2;
  logic [WIDTH-1:0] r_step;

  // One step: r = (2r + bit*mcand) mod n, with 2r + mcand below 3n.
  always_comb begin
    t_sum  = {1'b0, r_q, 1'b0} + {2'b00, (mpl_q[WIDTH-1] ? mcand_q : '0)};
    n1     = {2'b00, modulus_i};
    n2     = {1'b0, modulus_i, 1'b0};
    c1     = t_sum - n1;
    c2     = t_sum - n2;
    if (modulus_i == '0) begin
      r_step = t_sum[WIDTH-1:0];
    end else if (t_sum >= n2) begin
      r_step = c2[WIDTH-1:0];
    end else if (t_sum >= n1) begin
      r_step = c1[WIDTH-1:0];
    end else begin
      r_step = t_sum[WIDTH-1:0];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    mpl_d   = mpl_q;
    mcand_d = mcand_q;
    r_d     = r_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CNT_W'(WIDTH);
      mpl_d   = mplier_i;
      mcand_d = mcand_i;
      r_d     = '0;
    end else if (busy_q) begin
      r_d   = r_step;
      mpl_d = {mpl_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mpl_q   <= mpl_d;
    mcand_q <= mcand_d;
    r_q     <= r_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

  // The partial result stays reduced throughout a run.
  a_partial_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (modulus_i != '0) |-> r_q < modulus_i)
    else $error("partial result not reduced");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while still busy");

  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && (cnt_q == CNT_W'(WIDTH)))
    else $error("start did not load the step counter");

endmodule

/* hw/rtl/modular_exponentiation_top.sv */
// Sequence: the base is reduced first, then per exponent bit the block squares and,
//   when the bit is set, multiplies; the highest set bit skips its square.
// Throughput: one item at a time, paced by the shared bit-serial multiply-reduce
//   unit at one multiplier bit per cycle; a zero exponent goes straight to output.
// Reset: asynchronous active low; clears control and sets the modulus to 1.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square-and-multiply over a configured modulus, using one
// bit-serial modular multiplier for base reduction, multiply and square.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int unsigned WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mexp_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mexp_pkg::FIELD_W-1:0] base_value_i,
  input  logic [mexp_pkg::FIELD_W-1:0] exponent_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mexp_pkg::FIELD_W-1:0] power_o
);
  import mexp_pkg::*;

  mexp_state_e      state_q, state_d;
  mexp_op_e         op_sel;
  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] sq_q, sq_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] power_q;
  logic             out_load;

  logic             mul_start;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;
  logic [WIDTH-1:0] mul_mplier;
  logic [WIDTH-1:0] mul_mcand;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    op_sel    = OP_SQR;
    mul_start = 1'b0;
    acc_d     = acc_q;
    sq_d      = sq_q;
    exp_d     = exp_q;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          exp_d     = exponent_i[WIDTH-1:0];
          acc_d     = WIDTH'(1);
          op_sel    = OP_REDUCE;
          mul_start = 1'b1;
          state_d   = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mul_done) begin
          sq_d    = mul_res;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (exp_q == '0) begin
          state_d = S_OUT;
        end else if (exp_q[0]) begin
          op_sel    = OP_MUL;
          mul_start = 1'b1;
          state_d   = S_MUL;
        end else begin
          op_sel    = OP_SQR;
          mul_start = 1'b1;
          state_d   = S_SQR;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          acc_d = mul_res;
          // Skip the square when no higher exponent bit is left.
          if (exp_q[WIDTH-1:1] == '0) begin
            state_d = S_OUT;
          end else begin
            op_sel    = OP_SQR;
            mul_start = 1'b1;
            state_d   = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mul_done) begin
          sq_d    = mul_res;
          exp_d   = {1'b0, exp_q[WIDTH-1:1]};
          state_d = S_NEXT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (op_sel)
      OP_REDUCE: begin
        mul_mplier = base_value_i[WIDTH-1:0];
        mul_mcand  = WIDTH'(1);
      end
      OP_MUL: begin
        mul_mplier = acc_q;
        mul_mcand  = sq_q;
      end
      OP_SQR: begin
        mul_mplier = sq_q;
        mul_mcand  = sq_q;
      end
      default: begin
        mul_mplier = sq_q;
        mul_mcand  = sq_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  mexp_mulred #(
    .WIDTH(WIDTH)
  ) u_mulred (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mplier_i  (mul_mplier),
    .mcand_i   (mul_mcand),
    .modulus_i (modulus_q),
    .done_o    (mul_done),
    .result_o  (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= WIDTH'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i[WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sq_q  <= sq_d;
    exp_q <= exp_d;
    if (out_load) begin
      power_q <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign power_o     = FIELD_W'(power_q);

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_REDUCE)
    else $error("accepted beat did not start base reduction");

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_REDUCE) || (state_q == S_MUL) || (state_q == S_SQR))
    else $error("multiplier finished outside a wait state");

  a_square_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEXT) && (modulus_q != '0) |-> sq_q < modulus_q)
    else $error("square not reduced");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && out_valid_q && out_stall_i |=> state_q == S_OUT)
    else $error("result dropped while output register busy");

endmodule
